// ===== hw/rtl/ohlcv_pkg.sv =====
// shared types, constants and register map of the bar resampler
package ohlcv_pkg;

  // default number of tracked securities
  localparam int NUM_SECURITIES_DEF = 16;

  // field widths
  localparam int SEC_FIELD_W = 4;
  localparam int WORD_W      = 32;
  localparam int GRAN_W      = 17;

  // granularity limits and register reset values
  localparam logic [GRAN_W-1:0] GRAN_MIN          = 17'd60;
  localparam logic [GRAN_W-1:0] GRAN_MAX          = 17'd86400;
  localparam logic [GRAN_W-1:0] GRAN_RESET        = 17'd60;
  localparam logic [WORD_W-1:0] SESSION_START_RST = 32'd0;
  localparam logic [WORD_W-1:0] SESSION_END_RST   = 32'hFFFF_FFFF;

  // remainder unit: one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // apb register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_GRAN          = 2'd0;
  localparam logic [1:0] REG_SESSION_START = 2'd1;
  localparam logic [1:0] REG_SESSION_END   = 2'd2;
  localparam logic [PADDR_W-1:0] ADDR_SESSION_START = 4'd4;

  // request commands
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // input request
  typedef struct packed {
    logic                   command;
    logic [SEC_FIELD_W-1:0] security;
    logic [WORD_W-1:0]      timestamp;
    logic [WORD_W-1:0]      open_price;
    logic [WORD_W-1:0]      close_price;
    logic [WORD_W-1:0]      low_price;
    logic [WORD_W-1:0]      high_price;
    logic [WORD_W-1:0]      traded_volume;
  } rec_in_t;

  // emitted bar
  typedef struct packed {
    logic [SEC_FIELD_W-1:0] bar_security;
    logic [WORD_W-1:0]      bar_start;
    logic [WORD_W-1:0]      bar_open;
    logic [WORD_W-1:0]      bar_high;
    logic [WORD_W-1:0]      bar_low;
    logic [WORD_W-1:0]      bar_close;
    logic [WORD_W-1:0]      bar_volume;
  } bar_out_t;

  // per-security accumulator entry
  typedef struct packed {
    logic [WORD_W-1:0] open_p;
    logic [WORD_W-1:0] high_p;
    logic [WORD_W-1:0] low_p;
    logic [WORD_W-1:0] close_p;
    logic [WORD_W-1:0] volume;
  } acc_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [GRAN_W-1:0] gran_eff;
    logic [WORD_W-1:0] session_start;
    logic [WORD_W-1:0] session_end;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic commit;
    logic sweep;
    logic sweep_clr_hd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sec_ok;
    logic is_flush;
    logic in_session;
    logic advance;
    logic has_data;
    logic emit;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/ohlcv_cfg.sv =====
// apb configuration registers with granularity clamp
module ohlcv_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ohlcv_pkg::PADDR_W-1:0]    paddr,
  input  logic [ohlcv_pkg::PDATA_W-1:0]    pwdata,
  output logic [ohlcv_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready,
  output ohlcv_pkg::cfg_t                  cfg,
  output logic                             ss_wr
);

  logic [ohlcv_pkg::GRAN_W-1:0] gran;
  logic [ohlcv_pkg::WORD_W-1:0] session_start;
  logic [ohlcv_pkg::WORD_W-1:0] session_end;
  logic [1:0]                   reg_idx;
  logic                         wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;
  assign ss_wr   = wr && (reg_idx == ohlcv_pkg::REG_SESSION_START);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gran          <= ohlcv_pkg::GRAN_RESET;
      session_start <= ohlcv_pkg::SESSION_START_RST;
      session_end   <= ohlcv_pkg::SESSION_END_RST;
    end else if (wr) begin
      unique case (reg_idx)
        ohlcv_pkg::REG_GRAN:          gran          <= pwdata[ohlcv_pkg::GRAN_W-1:0];
        ohlcv_pkg::REG_SESSION_START: session_start <= pwdata;
        ohlcv_pkg::REG_SESSION_END:   session_end   <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      ohlcv_pkg::REG_GRAN:          prdata = ohlcv_pkg::PDATA_W'(gran);
      ohlcv_pkg::REG_SESSION_START: prdata = session_start;
      ohlcv_pkg::REG_SESSION_END:   prdata = session_end;
      default:                      prdata = '0;
    endcase
  end

  // clamp granularity into its legal range
  always_comb begin
    cfg.session_start = session_start;
    cfg.session_end   = session_end;
    if (gran < ohlcv_pkg::GRAN_MIN) begin
      cfg.gran_eff = ohlcv_pkg::GRAN_MIN;
    end else if (gran > ohlcv_pkg::GRAN_MAX) begin
      cfg.gran_eff = ohlcv_pkg::GRAN_MAX;
    end else begin
      cfg.gran_eff = gran;
    end
  end

endmodule

// ===== hw/rtl/ohlcv_rem.sv =====
// restoring remainder unit, one dividend bit per cycle
module ohlcv_rem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ohlcv_pkg::WORD_W-1:0]   dividend,
  input  logic [ohlcv_pkg::GRAN_W-1:0]   divisor,
  output logic                           done,
  output logic [ohlcv_pkg::GRAN_W-1:0]   rem
);

  logic [ohlcv_pkg::WORD_W-1:0]    q;
  logic [ohlcv_pkg::DIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic [ohlcv_pkg::GRAN_W:0]      trial;
  logic [ohlcv_pkg::GRAN_W:0]      diff;
  logic                            ge;

  // shift in next bit and try a subtract
  assign trial = {rem, q[ohlcv_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      cnt <= ohlcv_pkg::DIV_CNT_W'(ohlcv_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      q   <= q << 1;
      rem <= ge ? diff[ohlcv_pkg::GRAN_W-1:0] : trial[ohlcv_pkg::GRAN_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/ohlcv_dp.sv =====
// datapath: per-security state memories, window logic, merge and output register
module ohlcv_dp #(
  parameter int NUM_SECURITIES = ohlcv_pkg::NUM_SECURITIES_DEF,
  parameter int SEC_W          = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ohlcv_pkg::cfg_t      cfg,
  input  ohlcv_pkg::dp_cmd_t   cmd,
  output ohlcv_pkg::dp_stat_t  stat,
  input  logic [SEC_W-1:0]     sweep_addr,
  input  ohlcv_pkg::rec_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ohlcv_pkg::bar_out_t  out_data
);

  logic [ohlcv_pkg::WORD_W-1:0] ws_mem  [NUM_SECURITIES];
  logic                         hd_mem  [NUM_SECURITIES];
  ohlcv_pkg::acc_t              acc_mem [NUM_SECURITIES];

  ohlcv_pkg::rec_in_t           item;
  logic [ohlcv_pkg::WORD_W-1:0] rd_ws;
  logic                         rd_hd;
  ohlcv_pkg::acc_t              rd_acc;

  logic [SEC_W-1:0]             rd_addr;
  logic [SEC_W-1:0]             wr_addr;
  logic [ohlcv_pkg::WORD_W:0]   win_end;
  logic                         advance;
  logic                         is_flush;
  logic                         hd_eff;
  logic                         emit;
  logic [ohlcv_pkg::WORD_W-1:0] ws_new;
  ohlcv_pkg::acc_t              acc_new;
  logic [ohlcv_pkg::GRAN_W-1:0] rem;
  logic                         div_done;

  assign rd_addr = SEC_W'(in_data.security);
  assign wr_addr = SEC_W'(item.security);

  // latch request and read its security's state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item   <= in_data;
      rd_ws  <= ws_mem[rd_addr];
      rd_hd  <= hd_mem[rd_addr];
      rd_acc <= acc_mem[rd_addr];
    end
  end

  // window checks
  assign is_flush = (item.command == ohlcv_pkg::CMD_FLUSH);
  assign win_end  = {1'b0, rd_ws} + (ohlcv_pkg::WORD_W + 1)'(cfg.gran_eff);
  assign advance  = {1'b0, item.timestamp} >= win_end;
  assign emit     = is_flush ? rd_hd : (advance && rd_hd);
  assign hd_eff   = rd_hd && !advance;

  // distance into the window modulo granularity
  ohlcv_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (item.timestamp - rd_ws),
    .divisor  (cfg.gran_eff),
    .done     (div_done),
    .rem      (rem)
  );

  // new window start is the last grid point at or below the timestamp
  assign ws_new = advance ? (item.timestamp - ohlcv_pkg::WORD_W'(rem)) : rd_ws;

  // merge minute bar into the accumulator
  always_comb begin
    acc_new.close_p = item.close_price;
    if (hd_eff) begin
      acc_new.open_p = rd_acc.open_p;
      acc_new.low_p  = (item.low_price < rd_acc.low_p) ? item.low_price : rd_acc.low_p;
      acc_new.high_p = (item.high_price > rd_acc.high_p) ? item.high_price : rd_acc.high_p;
      acc_new.volume = rd_acc.volume + item.traded_volume;
    end else begin
      acc_new.open_p = item.open_price;
      acc_new.low_p  = item.low_price;
      acc_new.high_p = item.high_price;
      acc_new.volume = item.traded_volume;
    end
  end

  // memory writes: init sweep or commit of one request
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      ws_mem[sweep_addr] <= cfg.session_start;
      if (cmd.sweep_clr_hd) begin
        hd_mem[sweep_addr] <= 1'b0;
      end
    end else if (cmd.commit) begin
      hd_mem[wr_addr] <= !is_flush;
      if (!is_flush) begin
        ws_mem[wr_addr]  <= ws_new;
        acc_mem[wr_addr] <= acc_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      out_data.bar_security <= item.security;
      out_data.bar_start    <= rd_ws;
      out_data.bar_open     <= rd_acc.open_p;
      out_data.bar_high     <= rd_acc.high_p;
      out_data.bar_low      <= rd_acc.low_p;
      out_data.bar_close    <= rd_acc.close_p;
      out_data.bar_volume   <= rd_acc.volume;
    end
  end

  // status to controller
  always_comb begin
    stat.sec_ok     = ohlcv_pkg::WORD_W'(item.security) < ohlcv_pkg::WORD_W'(NUM_SECURITIES);
    stat.is_flush   = is_flush;
    stat.in_session = (item.timestamp >= cfg.session_start) &&
                      (item.timestamp < cfg.session_end);
    stat.advance    = advance;
    stat.has_data   = rd_hd;
    stat.emit       = emit;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== hw/rtl/ohlcv_ctrl.sv =====
// controller: request sequencing and state memory init sweeps
module ohlcv_ctrl #(
  parameter int NUM_SECURITIES = ohlcv_pkg::NUM_SECURITIES_DEF,
  parameter int SEC_W          = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 ss_wr,
  input  ohlcv_pkg::dp_stat_t  stat,
  output ohlcv_pkg::dp_cmd_t   cmd,
  output logic [SEC_W-1:0]     sweep_addr
);

  localparam int CNT_W = $clog2(NUM_SECURITIES + 1);

  typedef enum logic [4:0] {
    S_SWEEP  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIV    = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             clr_hd;
  logic             clr_hd_next;
  logic             pend;
  logic             pend_next;
  logic             sweep_last;

  assign sweep_addr = cnt[SEC_W-1:0];
  assign sweep_last = (cnt == CNT_W'(NUM_SECURITIES - 1));
  assign in_ready   = (state == S_IDLE) && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      cnt    <= '0;
      clr_hd <= 1'b1;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      clr_hd <= clr_hd_next;
      pend   <= pend_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next       = state;
    cnt_next         = '0;
    clr_hd_next      = clr_hd;
    pend_next        = pend || ss_wr;
    cmd.accept       = 1'b0;
    cmd.div_start    = 1'b0;
    cmd.commit       = 1'b0;
    cmd.sweep        = 1'b0;
    cmd.sweep_clr_hd = clr_hd;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sweep_last) begin
          clr_hd_next = 1'b0;
          state_next  = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (pend) begin
          pend_next  = ss_wr;
          state_next = S_SWEEP;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.sec_ok) begin
          state_next = S_IDLE;
        end else if (stat.is_flush) begin
          state_next = stat.has_data ? S_COMMIT : S_IDLE;
        end else if (!stat.in_session) begin
          state_next = S_IDLE;
        end else if (stat.advance) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold while a bar must go out and the output register is full
        if (!stat.emit || stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ohlcv_bar_resampler_core.sv =====
// top level of the ohlcv bar resampler
// Merges per-security one-minute bars into bars of a programmable length and
// emits each finished bar on the output channel. A request passes through accept,
// state read and check, then commit when it stays in its current window or
// flushes an open bar; through accept and check only when it is dropped or flushes
// a security with no open bar; and through accept, check, the remainder unit and
// commit when it moves the window forward, the one-bit-per-cycle remainder unit finding the new window start.
// A commit that emits a bar waits as long as the output register is still full.
// After reset, and after every session_start write, a sweep over all NUM_SECURITIES
// entries rewrites the per-security window starts (after reset it also clears
// the open-bar flags); in_ready stays low during the sweep. A finished bar waits
// in the output register while the next request is taken in.
module ohlcv_bar_resampler_core #(
  parameter int NUM_SECURITIES = ohlcv_pkg::NUM_SECURITIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ohlcv_pkg::rec_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ohlcv_pkg::bar_out_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ohlcv_pkg::PADDR_W-1:0]   paddr,
  input  logic [ohlcv_pkg::PDATA_W-1:0]   pwdata,
  output logic [ohlcv_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);

  localparam int SEC_W = (NUM_SECURITIES > 1) ? $clog2(NUM_SECURITIES) : 1;

  ohlcv_pkg::cfg_t     cfg;
  ohlcv_pkg::dp_cmd_t  cmd;
  ohlcv_pkg::dp_stat_t stat;
  logic                ss_wr;
  logic [SEC_W-1:0]    sweep_addr;

  // configuration registers
  ohlcv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .ss_wr   (ss_wr)
  );

  // controller
  ohlcv_ctrl #(
    .NUM_SECURITIES (NUM_SECURITIES),
    .SEC_W          (SEC_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ss_wr      (ss_wr),
    .stat       (stat),
    .cmd        (cmd),
    .sweep_addr (sweep_addr)
  );

  // datapath
  ohlcv_dp #(
    .NUM_SECURITIES (NUM_SECURITIES),
    .SEC_W          (SEC_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .sweep_addr (sweep_addr),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/ohlcv_checker.sv =====
// port-level checker for the bar resampler, bound to the top level
module ohlcv_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input ohlcv_pkg::bar_out_t           out_data,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ohlcv_pkg::PADDR_W-1:0] paddr
);

  // reset starts the init sweep, so no request is taken right after it
  a_sweep_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // no bar is pending right after reset
  a_out_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on two consecutive cycles");

  // a session start write blocks requests for the rewrite sweep
  a_ss_write_blocks: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr == ohlcv_pkg::ADDR_SESSION_START) |=> !in_ready)
    else $error("request taken right after a session start write");

  // a stalled bar holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled bar changed or dropped");

endmodule

bind ohlcv_bar_resampler_core ohlcv_checker u_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench of the ohlcv bar resampler core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEC          = ohlcv_pkg::NUM_SECURITIES_DEF;
  localparam int MAX_GAP       = 18;
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int NUM_PHASES    = 6;

  localparam logic [ohlcv_pkg::WORD_W-1:0] ONES = 32'hFFFF_FFFF;

  // register addresses, one index past the map included
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [ohlcv_pkg::PADDR_W-1:0] ADDR_GRAN     = {ohlcv_pkg::REG_GRAN, 2'b00};
  localparam logic [ohlcv_pkg::PADDR_W-1:0] ADDR_SESS_END = {ohlcv_pkg::REG_SESSION_END, 2'b00};
  localparam logic [ohlcv_pkg::PADDR_W-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_BAR} chk_t;
  typedef enum logic {ROW_REQ, ROW_REG} row_t;

  typedef struct {
    row_t                            kind;
    logic [ohlcv_pkg::PADDR_W-1:0]   addr;
    logic [ohlcv_pkg::WORD_W-1:0]    wdata;
    ohlcv_pkg::rec_in_t              req;
    chk_t                            chk;
    ohlcv_pkg::bar_out_t             bar;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  ohlcv_pkg::rec_in_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  ohlcv_pkg::bar_out_t             out_data;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ohlcv_pkg::PADDR_W-1:0]   paddr;
  logic [ohlcv_pkg::PDATA_W-1:0]   pwdata;
  logic [ohlcv_pkg::PDATA_W-1:0]   prdata;
  logic                            pready;

  ohlcv_bar_resampler_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow registers and per-security bar state
  logic [ohlcv_pkg::GRAN_W-1:0] gran_reg;
  logic [ohlcv_pkg::WORD_W-1:0] sess_start;
  logic [ohlcv_pkg::WORD_W-1:0] sess_end;
  logic [ohlcv_pkg::WORD_W-1:0] win_start [NSEC];
  bit                           open_bar  [NSEC];
  logic [ohlcv_pkg::WORD_W-1:0] acc_open  [NSEC];
  logic [ohlcv_pkg::WORD_W-1:0] acc_high  [NSEC];
  logic [ohlcv_pkg::WORD_W-1:0] acc_low   [NSEC];
  logic [ohlcv_pkg::WORD_W-1:0] acc_close [NSEC];
  logic [ohlcv_pkg::WORD_W-1:0] acc_vol   [NSEC];

  // per-security time cursor of the random record stream
  logic [63:0] cursor [NSEC];

  ohlcv_pkg::bar_out_t pending_bars [$];
  stim_row_t           dir_rows [$];
  int                  mismatches  = 0;
  int                  in_quiet    = 0;
  int                  out_quiet   = 0;
  int                  idle_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // append to the expected bar queue
  function automatic void book_bar(input ohlcv_pkg::bar_out_t b);
    pending_bars.insert(pending_bars.size(), b);
  endfunction

  // append to the directed stimulus table
  function automatic void append_row(input stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // bar length after clamping to the legal range
  function automatic logic [63:0] bar_len();
    if (gran_reg < ohlcv_pkg::GRAN_MIN) return 64'(ohlcv_pkg::GRAN_MIN);
    if (gran_reg > ohlcv_pkg::GRAN_MAX) return 64'(ohlcv_pkg::GRAN_MAX);
    return 64'(gran_reg);
  endfunction

  // hand out the open bar of one security and clear it
  function automatic ohlcv_pkg::bar_out_t take_bar(input int s);
    ohlcv_pkg::bar_out_t b;
    b.bar_security = ohlcv_pkg::SEC_FIELD_W'(s);
    b.bar_start    = win_start[s];
    b.bar_open     = acc_open[s];
    b.bar_high     = acc_high[s];
    b.bar_low      = acc_low[s];
    b.bar_close    = acc_close[s];
    b.bar_volume   = acc_vol[s];
    open_bar[s]  = 1'b0;
    acc_open[s]  = '0;
    acc_high[s]  = '0;
    acc_low[s]   = '0;
    acc_close[s] = '0;
    acc_vol[s]   = '0;
    return b;
  endfunction

  // next bar state for one request; returns 1 when a bar is emitted
  function automatic bit resample_bar(input ohlcv_pkg::rec_in_t r,
                                      output ohlcv_pkg::bar_out_t b);
    int          s;
    logic [63:0] g;
    logic [63:0] span;
    bit          emitted;
    s       = int'(r.security);
    emitted = 1'b0;
    b       = '0;
    if (r.command == ohlcv_pkg::CMD_FLUSH) begin
      if (!open_bar[s]) return 1'b0;
      b = take_bar(s);
      return 1'b1;
    end
    if (r.timestamp < sess_start || r.timestamp >= sess_end) return 1'b0;
    g = bar_len();
    // window advance in whole bar lengths, computed wide so it never wraps
    if ({32'd0, r.timestamp} >= {32'd0, win_start[s]} + g) begin
      span = {32'd0, r.timestamp} - {32'd0, win_start[s]};
      if (open_bar[s]) begin
        b       = take_bar(s);
        emitted = 1'b1;
      end
      win_start[s] = ohlcv_pkg::WORD_W'({32'd0, win_start[s]} + (span / g) * g);
    end
    // merge into the current window
    if (!open_bar[s]) begin
      acc_open[s] = r.open_price;
      acc_low[s]  = r.low_price;
      acc_high[s] = r.high_price;
      open_bar[s] = 1'b1;
    end
    acc_close[s] = r.close_price;
    if (r.low_price < acc_low[s]) acc_low[s] = r.low_price;
    if (r.high_price > acc_high[s]) acc_high[s] = r.high_price;
    acc_vol[s] = acc_vol[s] + r.traded_volume;
    return emitted;
  endfunction

  // idle cycles before the next handshake, with stretches of none
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet_left = int'($urandom_range(10, 40));
      return 0;
    end
    return int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic ohlcv_pkg::rec_in_t mk_req(
      input logic cmd, input logic [ohlcv_pkg::SEC_FIELD_W-1:0] sec,
      input logic [ohlcv_pkg::WORD_W-1:0] ts, input logic [ohlcv_pkg::WORD_W-1:0] op,
      input logic [ohlcv_pkg::WORD_W-1:0] cp, input logic [ohlcv_pkg::WORD_W-1:0] lp,
      input logic [ohlcv_pkg::WORD_W-1:0] hp, input logic [ohlcv_pkg::WORD_W-1:0] vol);
    ohlcv_pkg::rec_in_t r;
    r.command       = cmd;
    r.security      = sec;
    r.timestamp     = ts;
    r.open_price    = op;
    r.close_price   = cp;
    r.low_price     = lp;
    r.high_price    = hp;
    r.traded_volume = vol;
    return r;
  endfunction

  function automatic void add_req(input ohlcv_pkg::rec_in_t r, input chk_t chk,
                                  input ohlcv_pkg::bar_out_t b);
    stim_row_t row;
    row.kind  = ROW_REQ;
    row.addr  = '0;
    row.wdata = '0;
    row.req   = r;
    row.chk   = chk;
    row.bar   = b;
    append_row(row);
  endfunction

  function automatic void add_reg(input logic [ohlcv_pkg::PADDR_W-1:0] addr,
                                  input logic [ohlcv_pkg::WORD_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.addr  = addr;
    row.wdata = data;
    row.req   = '0;
    row.chk   = CHK_NONE;
    row.bar   = '0;
    append_row(row);
  endfunction

  // random request: mostly ordered minute bars, some flushes and noise
  function automatic ohlcv_pkg::rec_in_t draw_request();
    ohlcv_pkg::rec_in_t           r;
    int                           s;
    int unsigned                  pick;
    int unsigned                  jump;
    logic [ohlcv_pkg::WORD_W-1:0] spread;
    logic [63:0]                  g;
    logic [63:0]                  t;
    g      = bar_len();
    s      = int'($urandom_range(0, NSEC - 1));
    pick   = $urandom_range(0, 99);
    spread = $urandom_range(0, 5000);
    r.command       = ohlcv_pkg::CMD_RECORD;
    r.security      = ohlcv_pkg::SEC_FIELD_W'(s);
    r.low_price     = $urandom;
    r.high_price    = r.low_price + spread;
    r.open_price    = r.low_price + $urandom_range(0, spread);
    r.close_price   = r.low_price + $urandom_range(0, spread);
    r.traded_volume = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1000000);
    if ($urandom_range(0, 4) == 0) begin
      r.open_price  = $urandom;
      r.close_price = $urandom;
      r.low_price   = $urandom;
      r.high_price  = $urandom;
    end
    if (pick < 70) begin
      // in-order record, often far enough to close the window
      jump = $urandom_range(0, 9);
      if (jump < 6) t = 64'(60 * $urandom_range(0, 2));
      else if (jump < 9) t = 64'($urandom_range(0, 32'(2 * g)));
      else t = 64'($urandom_range(0, 32'(20 * g)));
      cursor[s] = cursor[s] + t;
      if (cursor[s] >= {32'd0, sess_end}) cursor[s] = {32'd0, sess_start};
      t = cursor[s] + 64'($urandom_range(0, 59));
      if (t >= {32'd0, sess_end}) t = cursor[s];
      r.timestamp = t[ohlcv_pkg::WORD_W-1:0];
    end else if (pick < 80) begin
      r.command   = ohlcv_pkg::CMD_FLUSH;
      r.timestamp = $urandom;
    end else if (pick < 87) begin
      // behind the cursor, often before the window start
      t = cursor[s] - 64'($urandom_range(1, 600));
      if (cursor[s] < 64'd601 || t < {32'd0, sess_start}) t = {32'd0, sess_start};
      r.timestamp = t[ohlcv_pkg::WORD_W-1:0];
    end else if (pick < 94) begin
      // session boundaries and stray times
      case ($urandom_range(0, 2))
        0: r.timestamp = $urandom;
        1: r.timestamp = sess_end;
        default: r.timestamp = sess_start - 32'd1;
      endcase
    end else begin
      r.command       = 1'($urandom_range(0, 1));
      r.timestamp     = $urandom;
      r.open_price    = $urandom;
      r.close_price   = $urandom;
      r.low_price     = $urandom;
      r.high_price    = $urandom;
      r.traded_volume = $urandom;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ohlcv_pkg::WORD_W-1:0] want,
                             input logic [ohlcv_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // apb write with readback of mapped registers
  task automatic program_reg(input logic [ohlcv_pkg::PADDR_W-1:0] addr,
                             input logic [ohlcv_pkg::WORD_W-1:0] wdata);
    logic [ohlcv_pkg::WORD_W-1:0] readback;
    bit                           mapped;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    mapped = 1'b1;
    case (addr[3:2])
      ohlcv_pkg::REG_GRAN: begin
        gran_reg = wdata[ohlcv_pkg::GRAN_W-1:0];
        readback = {{(ohlcv_pkg::WORD_W-ohlcv_pkg::GRAN_W){1'b0}}, gran_reg};
      end
      ohlcv_pkg::REG_SESSION_START: begin
        sess_start = wdata;
        foreach (win_start[s]) win_start[s] = wdata;
        readback = wdata;
      end
      ohlcv_pkg::REG_SESSION_END: begin
        sess_end = wdata;
        readback = wdata;
      end
      default: begin
        mapped   = 1'b0;
        readback = '0;
      end
    endcase
    if (mapped) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      check_field("register readback", readback, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // drain all bars, then let a dropped request finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // drive one request and book the bar it causes
  task automatic send_request(input ohlcv_pkg::rec_in_t r, input chk_t chk,
                              input ohlcv_pkg::bar_out_t typed);
    int                  gap;
    ohlcv_pkg::bar_out_t b;
    bit                  has_bar;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    has_bar = resample_bar(r, b);
    case (chk)
      CHK_MODEL: if (has_bar) book_bar(b);
      CHK_BAR:   book_bar(typed);
      default:   ;
    endcase
  endtask

  // output side: random stalls, compare against the oldest booked bar
  initial begin : bar_monitor
    int                  gap;
    ohlcv_pkg::bar_out_t want;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap(out_quiet);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_bars.size() == 0) begin
        $display("%0t ns: bar of security %0d start %h with none expected",
                 $time, out_data.bar_security, out_data.bar_start);
        mismatches++;
      end else begin
        want = pending_bars.pop_front();
        check_field("bar_security", 32'(want.bar_security), 32'(out_data.bar_security));
        check_field("bar_start", want.bar_start, out_data.bar_start);
        check_field("bar_open", want.bar_open, out_data.bar_open);
        check_field("bar_high", want.bar_high, out_data.bar_high);
        check_field("bar_low", want.bar_low, out_data.bar_low);
        check_field("bar_close", want.bar_close, out_data.bar_close);
        check_field("bar_volume", want.bar_volume, out_data.bar_volume);
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [ohlcv_pkg::GRAN_W-1:0] ph_gran;
    logic [ohlcv_pkg::WORD_W-1:0] ph_start;
    logic [ohlcv_pkg::WORD_W-1:0] ph_end;
    logic [63:0]                  span_end;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    gran_reg   = ohlcv_pkg::GRAN_RESET;
    sess_start = ohlcv_pkg::SESSION_START_RST;
    sess_end   = ohlcv_pkg::SESSION_END_RST;
    for (int s = 0; s < NSEC; s++) begin
      win_start[s] = ohlcv_pkg::SESSION_START_RST;
      void'(take_bar(s));
      cursor[s] = '0;
    end

    // directed rows at reset settings: merge, volume wrap, flush with and without data
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd0, 32'd100, 32'd10, 32'd20, 32'd5, 32'd30,
                   32'd7), CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd0, 32'd110, ONES, 32'd25, 32'd3, 32'd40, ONES),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_FLUSH, 4'd0, ONES, ONES, ONES, ONES, ONES, ONES), CHK_BAR,
            ohlcv_pkg::bar_out_t'{4'd0, 32'd60, 32'd10, 32'd40, 32'd3, 32'd25, 32'd6});
    add_req(mk_req(ohlcv_pkg::CMD_FLUSH, 4'd0, '0, '0, '0, '0, '0, '0), CHK_NONE, '0);
    // session end boundary and a window whose end lies past 2^32
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd15, ONES, ONES, ONES, ONES, ONES, ONES),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd15, 32'hFFFF_FFFE, ONES, ONES, ONES, ONES, ONES),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd15, 32'hFFFF_FFF0, '0, '0, '0, '0, 32'd1),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_FLUSH, 4'd15, '0, '0, '0, '0, '0, '0), CHK_BAR,
            ohlcv_pkg::bar_out_t'{4'd15, 32'hFFFF_FFF0, ONES, ONES, 32'd0, 32'd0, 32'd0});
    // window close on the exact boundary, then a record before the window
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd59, 32'd1, 32'd2, 32'd0, 32'd3, 32'd4),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd60, 32'd5, 32'd6, 32'd1, 32'd7, 32'd8),
            CHK_BAR, ohlcv_pkg::bar_out_t'{4'd3, 32'd0, 32'd1, 32'd3, 32'd0, 32'd2, 32'd4});
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd0, 32'd9, 32'd9, 32'd0, 32'd9, 32'd1),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd300, 32'd20, 32'd21, 32'd19, 32'd22,
                   32'd2),
            CHK_BAR, ohlcv_pkg::bar_out_t'{4'd3, 32'd60, 32'd5, 32'd9, 32'd0, 32'd9, 32'd9});
    // granularity below the minimum, narrow session, pending data kept
    add_reg(ADDR_GRAN, 32'd0);
    add_reg(ADDR_SESS_END, 32'd2000);
    add_reg(ohlcv_pkg::ADDR_SESSION_START, 32'd1000);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd999, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd2000, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1),
            CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd1000, 32'd30, 32'd31, 32'd10, 32'd40,
                   32'd3), CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd3, 32'd1999, 32'd50, 32'd51, 32'd49, 32'd52,
                   32'd6),
            CHK_BAR,
            ohlcv_pkg::bar_out_t'{4'd3, 32'd1000, 32'd20, 32'd40, 32'd10, 32'd31, 32'd5});
    // granularity above the maximum, upper data bits dropped
    add_reg(ADDR_GRAN, ONES);
    add_reg(ohlcv_pkg::ADDR_SESSION_START, 32'd0);
    add_reg(ADDR_SESS_END, ONES);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd7, 32'd86399, 32'd100, 32'd101, 32'd99, 32'd102,
                   32'd10), CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd7, 32'd86400, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1),
            CHK_BAR,
            ohlcv_pkg::bar_out_t'{4'd7, 32'd0, 32'd100, 32'd102, 32'd99, 32'd101, 32'd10});
    // write past the register map leaves the bar length alone
    add_reg(ADDR_UNMAPPED, 32'd60);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd7, 32'd172799, 32'd2, 32'd2, 32'd2, 32'd2,
                   32'd2), CHK_NONE, '0);
    add_req(mk_req(ohlcv_pkg::CMD_FLUSH, 4'd7, '0, '0, '0, '0, '0, '0), CHK_MODEL, '0);
    add_req(mk_req(ohlcv_pkg::CMD_FLUSH, 4'd3, ONES, '0, '0, '0, '0, '0), CHK_MODEL, '0);
    add_req(mk_req(ohlcv_pkg::CMD_RECORD, 4'd9, 32'h8000_0000, ONES, ONES, ONES, ONES, ONES),
            CHK_MODEL, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle();
        program_reg(dir_rows[i].addr, dir_rows[i].wdata);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].bar);
      end
    end

    // random phases over several register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          ph_gran  = ohlcv_pkg::GRAN_MIN;
          ph_start = '0;
          ph_end   = ONES;
        end
        1: begin
          ph_gran  = ohlcv_pkg::GRAN_MAX;
          ph_start = 32'h7FFF_0000;
          ph_end   = 32'h8010_0000;
        end
        2: begin
          ph_gran  = ohlcv_pkg::GRAN_W'($urandom_range(60, 86400));
          ph_start = $urandom_range(0, 32'hF000_0000);
          ph_end   = ph_start + $urandom_range(200000, 5000000);
        end
        3: begin
          ph_gran  = ohlcv_pkg::GRAN_MIN;
          ph_start = 32'hFFFF_0000;
          ph_end   = ONES;
        end
        4: begin
          ph_gran  = ohlcv_pkg::GRAN_W'($urandom_range(0, 131071));
          ph_start = $urandom_range(0, 1000);
          ph_end   = $urandom_range(32'h1000_0000, ONES);
        end
        default: begin
          ph_gran  = ohlcv_pkg::GRAN_W'($urandom_range(60, 3600));
          ph_start = $urandom_range(0, 1000000000);
          span_end = {32'd0, ph_start} + 64'd100000000;
          ph_end   = span_end[ohlcv_pkg::WORD_W-1:0];
        end
      endcase
      settle();
      program_reg(ADDR_GRAN, {{(ohlcv_pkg::WORD_W-ohlcv_pkg::GRAN_W){1'b0}}, ph_gran});
      program_reg(ADDR_SESS_END, ph_end);
      program_reg(ohlcv_pkg::ADDR_SESSION_START, ph_start);
      for (int s = 0; s < NSEC; s++) cursor[s] = {32'd0, sess_start};
      for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++) begin
        send_request(draw_request(), CHK_MODEL, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
